/* sv/assert_macros.svh */
// Assertion macros shared by the LCD sequencer modules.
// No dependencies; included by each module that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

// Checks that a trigger at one edge is followed by a consequence at the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* sv/lcd4_pkg.sv */
// Shared types, codes and init tables of the 4-bit character LCD sequencer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package lcd4_pkg;

	// Longest wait the timing counter can hold, and the counter width that follows.
	localparam int MAX_WAIT_US = 16383;
	localparam int WAIT_W = $clog2(MAX_WAIT_US + 1);

	// Power-up delay before the first init command.
	localparam logic [WAIT_W-1:0] POWER_WAIT_US = WAIT_W'(15000);

	// Number of commands in the init list.
	localparam logic [3:0] INIT_COUNT = 4'd10;
	localparam logic [3:0] INIT_FIRST_NO_PREAMBLE = 4'd2;

	// Action codes of an input word.
	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_INIT  = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_SKIP_PREAMBLE = 1'b0;
	localparam logic CFG_TICKS_PER_US  = 1'b1;

	typedef struct packed {
		logic [1:0]        action;
		logic [7:0]        byte_value;
		logic              is_data;
		logic [WAIT_W-1:0] settle_us;
	} in_t;

	typedef struct packed {
		logic       rs_pin;
		logic       en_pin;
		logic [3:0] data_nibble;
		logic       busy_res;
		logic       rejected;
	} out_t;

	// Classified word handed from the front queue to the sequencer.
	typedef struct packed {
		logic              is_tick;
		logic              is_write;
		logic              is_init;
		logic [7:0]        byte_value;
		logic              is_data;
		logic [WAIT_W-1:0] settle_us;
	} cmd_t;

	// Init command list.
	function automatic logic [7:0] init_cmd(input logic [3:0] idx);
		logic [7:0] v;
		case (idx)
			4'd0: v = 8'h33;
			4'd1: v = 8'h32;
			4'd2: v = 8'h28;
			4'd3: v = 8'h08;
			4'd4: v = 8'h0f;
			4'd5: v = 8'h01;
			4'd6: v = 8'h28;
			4'd7: v = 8'h0c;
			4'd8: v = 8'h06;
			4'd9: v = 8'h01;
			default: v = 8'h33;
		endcase
		return v;
	endfunction

	// Delay in microseconds after each init command.
	function automatic logic [WAIT_W-1:0] init_wait(input logic [3:0] idx);
		logic [WAIT_W-1:0] v;
		case (idx)
			4'd0: v = WAIT_W'(4000);
			4'd1: v = WAIT_W'(4000);
			4'd2: v = WAIT_W'(2000);
			4'd3: v = WAIT_W'(40);
			4'd4: v = WAIT_W'(40);
			4'd5: v = WAIT_W'(1800);
			4'd6: v = WAIT_W'(2000);
			4'd7: v = WAIT_W'(40);
			4'd8: v = WAIT_W'(40);
			4'd9: v = WAIT_W'(1800);
			default: v = WAIT_W'(4000);
		endcase
		return v;
	endfunction

endpackage

/* sv/lcd4_front.sv */
// Front queue of the LCD sequencer: accepts input words and classifies their action.
// Depends on lcd4_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lcd4_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  lcd4_pkg::in_t item,
	input  logic          take,
	output logic          avail,
	output lcd4_pkg::cmd_t cmd
);

	lcd4_pkg::cmd_t slot_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           do_push;
	logic           do_pop;
	lcd4_pkg::cmd_t cls;

	assign full    = (cnt_q == 2'd2);
	assign avail   = (cnt_q != 2'd0);
	assign do_push = push && !full;
	assign do_pop  = take && avail;
	assign cmd     = slot_q[rd_ptr_q];

	// Decode the action code into one flag per kind; unused codes set none.
	always_comb begin
		cls.is_tick    = (item.action == lcd4_pkg::ACT_TICK);
		cls.is_write   = (item.action == lcd4_pkg::ACT_WRITE);
		cls.is_init    = (item.action == lcd4_pkg::ACT_INIT);
		cls.byte_value = item.byte_value;
		cls.is_data    = item.is_data;
		cls.settle_us  = item.settle_us;
	end

	// Storage for the two queued words.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= cls;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	`ASSERT_ALWAYS(a_front_cnt_bound, clk, arst_n, cnt_q <= 2'd2)
	`ASSERT_NEXT(a_front_cnt_grow, clk, arst_n, do_push && !do_pop, cnt_q == $past(cnt_q) + 2'd1)

endmodule

/* sv/lcd4_seq.sv */
// Back end of the LCD sequencer: runs one queued word per cycle, while a word waits and the result queue
// has room, through the phase, timing and init-list state. Depends on lcd4_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lcd4_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic [7:0]      cfg_data,
	input  logic            avail,
	input  lcd4_pkg::cmd_t  cmd,
	output logic            take,
	input  logic            room,
	output logic            res_wr,
	output lcd4_pkg::out_t  res
);

	localparam logic [3:0] PH_IDLE   = 4'd0;
	localparam logic [3:0] PH_POWER  = 4'd1;
	localparam logic [3:0] PH_SETUP  = 4'd2;
	localparam logic [3:0] PH_ENLO1  = 4'd3;
	localparam logic [3:0] PH_ENHI   = 4'd4;
	localparam logic [3:0] PH_ENLO2  = 4'd5;
	localparam logic [3:0] PH_SETTLE = 4'd6;

	localparam int W = lcd4_pkg::WAIT_W;

	// Configuration registers.
	logic       skip_pre_q;
	logic [7:0] tpu_q;

	// Sequencer state.
	logic [3:0]   phase_q;
	logic         nib_q;
	logic [7:0]   byte_q;
	logic         rsl_q;
	logic [W-1:0] settle_q;
	logic [W-1:0] us_q;
	logic [7:0]   pre_q;
	logic [3:0]   step_q;
	logic         init_q;
	logic         en_q;
	logic [3:0]   data_q;
	logic         rs_q;

	// Next-state values.
	logic [3:0]   phase_d;
	logic         nib_d;
	logic [7:0]   byte_d;
	logic         rsl_d;
	logic [W-1:0] settle_d;
	logic [W-1:0] us_d;
	logic [7:0]   pre_d;
	logic [3:0]   step_d;
	logic         init_d;
	logic         en_d;
	logic [3:0]   data_d;
	logic         rs_d;
	logic         rej;

	logic         busy;
	logic         fire;
	logic         go_setup;
	logic         go_cmd;
	logic         go_finish;
	logic [3:0]   sel;

	assign busy   = (phase_q != PH_IDLE);
	assign fire   = avail && room;
	assign take   = fire;
	assign res_wr = fire;

	// One step of the sequencer for the word at the head of the front queue.
	always_comb begin
		phase_d   = phase_q;
		nib_d     = nib_q;
		byte_d    = byte_q;
		rsl_d     = rsl_q;
		settle_d  = settle_q;
		us_d      = us_q;
		pre_d     = pre_q;
		step_d    = step_q;
		init_d    = init_q;
		en_d      = en_q;
		data_d    = data_q;
		rs_d      = rs_q;
		rej       = 1'b0;
		go_setup  = 1'b0;
		go_cmd    = 1'b0;
		go_finish = 1'b0;
		sel       = 4'd0;

		if (cmd.is_tick) begin
			if (busy) begin
				pre_d = pre_q + 8'd1;
				if (pre_d >= tpu_q) begin
					pre_d = 8'd0;
					if (us_q != '0) begin
						us_d = us_q - W'(1);
					end
					if (us_d == '0) begin
						// The current phase has run out: move on to the next one.
						case (phase_q)
							PH_POWER: begin
								rs_d   = 1'b0;
								en_d   = 1'b1;
								data_d = 4'd0;
								go_cmd = 1'b1;
							end
							PH_SETUP: begin
								rs_d    = rsl_q;
								en_d    = 1'b0;
								phase_d = PH_ENLO1;
								us_d    = W'(5);
							end
							PH_ENLO1: begin
								en_d    = 1'b1;
								phase_d = PH_ENHI;
								us_d    = W'(10);
							end
							PH_ENHI: begin
								en_d    = 1'b0;
								phase_d = PH_ENLO2;
								us_d    = W'(5);
							end
							PH_ENLO2: begin
								if (!nib_q) begin
									nib_d    = 1'b1;
									go_setup = 1'b1;
								end else if (settle_q == '0) begin
									go_finish = 1'b1;
								end else begin
									phase_d = PH_SETTLE;
									us_d    = settle_q;
								end
							end
							PH_SETTLE: begin
								go_finish = 1'b1;
							end
							default: begin
								phase_d = PH_IDLE;
							end
						endcase
					end
				end
			end
		end else if (cmd.is_write || cmd.is_init) begin
			if (busy) begin
				rej = 1'b1;
			end else begin
				pre_d = 8'd0;
				if (cmd.is_write) begin
					byte_d   = cmd.byte_value;
					rsl_d    = cmd.is_data;
					settle_d = cmd.settle_us;
					nib_d    = 1'b0;
					go_setup = 1'b1;
				end else begin
					init_d  = 1'b1;
					step_d  = skip_pre_q ? lcd4_pkg::INIT_FIRST_NO_PREAMBLE : 4'd0;
					phase_d = PH_POWER;
					us_d    = lcd4_pkg::POWER_WAIT_US;
				end
			end
		end

		// A byte is done: either the next init command starts or the block goes idle.
		if (go_finish) begin
			if (init_q) begin
				step_d = step_q + 4'd1;
				if (step_d >= lcd4_pkg::INIT_COUNT) begin
					init_d  = 1'b0;
					step_d  = 4'd0;
					phase_d = PH_IDLE;
				end else begin
					go_cmd = 1'b1;
				end
			end else begin
				phase_d = PH_IDLE;
			end
		end

		// Load the next init command as an instruction byte.
		if (go_cmd) begin
			sel      = (step_d < lcd4_pkg::INIT_COUNT) ? step_d : 4'd0;
			byte_d   = lcd4_pkg::init_cmd(sel);
			rsl_d    = 1'b0;
			settle_d = lcd4_pkg::init_wait(sel);
			nib_d    = 1'b0;
			go_setup = 1'b1;
		end

		// Present the selected nibble and hold it for one microsecond.
		if (go_setup) begin
			phase_d = PH_SETUP;
			data_d  = nib_d ? byte_d[3:0] : byte_d[7:4];
			us_d    = W'(1);
		end
	end

	// Result word reflects the line levels after this step.
	always_comb begin
		res.rs_pin      = rs_d;
		res.en_pin      = en_d;
		res.data_nibble = data_d;
		res.busy_res    = (phase_d != PH_IDLE);
		res.rejected    = rej;
	end

	// Configuration registers are written directly.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_pre_q <= 1'b0;
			tpu_q      <= 8'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				lcd4_pkg::CFG_SKIP_PREAMBLE: skip_pre_q <= cfg_data[0];
				lcd4_pkg::CFG_TICKS_PER_US:  tpu_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer state advances once per word taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			nib_q    <= 1'b0;
			byte_q   <= 8'd0;
			rsl_q    <= 1'b0;
			settle_q <= '0;
			us_q     <= '0;
			pre_q    <= 8'd0;
			step_q   <= 4'd0;
			init_q   <= 1'b0;
			en_q     <= 1'b0;
			data_q   <= 4'd0;
			rs_q     <= 1'b0;
		end else if (fire) begin
			phase_q  <= phase_d;
			nib_q    <= nib_d;
			byte_q   <= byte_d;
			rsl_q    <= rsl_d;
			settle_q <= settle_d;
			us_q     <= us_d;
			pre_q    <= pre_d;
			step_q   <= step_d;
			init_q   <= init_d;
			en_q     <= en_d;
			data_q   <= data_d;
			rs_q     <= rs_d;
		end
	end

	`ASSERT_NEXT(a_seq_reject_holds, clk, arst_n, fire && rej, phase_q == $past(phase_q))

endmodule

/* sv/lcd4_outq.sv */
// Result queue of the LCD sequencer: holds finished result words until popped.
// Depends on lcd4_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lcd4_outq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	output logic           room,
	input  lcd4_pkg::out_t wdata,
	output logic           empty,
	input  logic           pop,
	output lcd4_pkg::out_t result
);

	lcd4_pkg::out_t slot_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           do_wr;
	logic           do_rd;

	assign room   = (cnt_q != 2'd2);
	assign empty  = (cnt_q == 2'd0);
	assign do_wr  = wr && room;
	assign do_rd  = pop && !empty;
	assign result = slot_q[rd_ptr_q];

	// Storage for the two result words.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	`ASSERT_ALWAYS(a_outq_cnt_bound, clk, arst_n, cnt_q <= 2'd2)

endmodule

/* sv/char_lcd_4bit_interface_sequencer.sv */
// 4-bit character LCD sequencer: front queue, sequencer step and result queue.
// A pushed word is stored in the front queue, then stepped and stored in the result queue.
// Throughput: one word per cycle while words arrive and the result queue has room.
// Both queues hold two words, so a stall on either side stops the other once they fill.
// Reset at once empties both queues and clears all state, but ticks per us resets to one.
`timescale 1ns / 1ps

module char_lcd_4bit_interface_sequencer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [7:0]     cfg_data,
	input  logic           push,
	output logic           full,
	input  lcd4_pkg::in_t  item,
	output logic           empty,
	input  logic           pop,
	output lcd4_pkg::out_t result
);

	logic           avail;
	logic           take;
	logic           room;
	logic           res_wr;
	lcd4_pkg::cmd_t cmd;
	lcd4_pkg::out_t res;

	// Front: accept and classify input words.
	lcd4_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.take   (take),
		.avail  (avail),
		.cmd    (cmd)
	);

	// Back: run each word through the sequencer.
	lcd4_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.avail     (avail),
		.cmd       (cmd),
		.take      (take),
		.room      (room),
		.res_wr    (res_wr),
		.res       (res)
	);

	// Result queue toward the consumer.
	lcd4_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_wr),
		.room   (room),
		.wdata  (res),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule
